// ----- rtl/crc32ra_pkg.sv -----
package crc32ra_pkg;

  localparam int DATA_W    = 64;
  localparam int CRC_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 2;
  localparam int IN_USER_W = SIZE_W + 1;

  // bytes folded per word at most, clamped to 1..8
  localparam int MAX_BYTES = 8;
  localparam int BYTE_CAP  = (MAX_BYTES < 1) ? 1 : ((MAX_BYTES > 8) ? 8 : MAX_BYTES);
  localparam int CNT_W     = (BYTE_CAP > 1) ? $clog2(BYTE_CAP) : 1;

  // fold matrix inputs: remainder bits, then data bits
  localparam int IN_BITS = CRC_W + DATA_W;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

  // queue between front and back, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt_m1;  // bytes used minus one
    logic              start;
    logic              last;
  } crc32ra_item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } crc32ra_qstat_t;

  typedef logic [BYTE_CAP-1:0][IN_BITS-1:0][CRC_W-1:0] crc32ra_mat_t;

  // bitwise reflected fold of nbytes bytes, elaboration only
  function automatic logic [CRC_W-1:0] fold_bits(logic [CRC_W-1:0] r_in,
                                                 logic [DATA_W-1:0] d, int nbytes);
    logic [CRC_W-1:0] r;
    r = r_in;
    for (int n = 0; n < 8; n++) begin
      if (n < nbytes) begin
        r = r ^ {{(CRC_W-BYTE_W){1'b0}}, d[BYTE_W*n +: BYTE_W]};
        for (int k = 0; k < BYTE_W; k++) begin
          r = (r >> 1) ^ (r[0] ? CRC_POLY : '0);
        end
      end
    end
    return r;
  endfunction

  // one column per input bit: the fold is linear once init is applied
  function automatic crc32ra_mat_t gen_mat();
    crc32ra_mat_t m;
    logic [CRC_W-1:0]  r;
    logic [DATA_W-1:0] d;
    for (int c = 0; c < BYTE_CAP; c++) begin
      for (int k = 0; k < IN_BITS; k++) begin
        r = '0;
        d = '0;
        if (k < CRC_W) r[k] = 1'b1;
        else           d[k-CRC_W] = 1'b1;
        m[c][k] = fold_bits(r, d, c + 1);
      end
    end
    return m;
  endfunction

  localparam crc32ra_mat_t FOLD_MAT = gen_mat();

endpackage

// ----- rtl/crc32ra_front.sv -----
module crc32ra_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crc32ra_pkg::DATA_W-1:0]      in_tdata,
  input  logic [crc32ra_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                                in_tlast,
  input  crc32ra_pkg::crc32ra_qstat_t         q_stat,
  output logic                                push,
  output crc32ra_pkg::crc32ra_item_t          push_item
);
  import crc32ra_pkg::*;

  logic [3:0] count_w;

  assign in_tready = ~q_stat.full;
  assign push      = in_tvalid & ~q_stat.full;

  // byte count from size code, capped
  always_comb begin
    count_w = 4'd1 << in_tuser[SIZE_W-1:0];
    if (count_w > 4'(BYTE_CAP)) count_w = 4'(BYTE_CAP);
    push_item.data   = in_tdata;
    push_item.cnt_m1 = CNT_W'(count_w - 4'd1);
    push_item.start  = in_tuser[SIZE_W];
    push_item.last   = in_tlast;
  end

endmodule

// ----- rtl/crc32ra_queue.sv -----
module crc32ra_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  crc32ra_pkg::crc32ra_item_t   push_item,
  input  logic                         pop,
  output crc32ra_pkg::crc32ra_item_t   head_item,
  output crc32ra_pkg::crc32ra_qstat_t  q_stat
);
  import crc32ra_pkg::*;

  crc32ra_item_t     mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head_item        = mem_r[rd_ptr_r];
  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.full      = (cnt_r == QCNT_W'(QDEPTH));

endmodule

// ----- rtl/crc32ra_back.sv -----
module crc32ra_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crc32ra_pkg::crc32ra_item_t    head_item,
  input  crc32ra_pkg::crc32ra_qstat_t   q_stat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [crc32ra_pkg::CRC_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import crc32ra_pkg::*;

  logic [CRC_W-1:0]   rem_r;
  logic [CRC_W-1:0]   r_in;
  logic [CRC_W-1:0]   r_new;
  logic [IN_BITS-1:0] vec;
  logic               out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0]   crc_r;
  logic               final_r;

  assign pop = q_stat.not_empty & (~out_valid_r | out_tready);

  // xor of the matrix columns selected by remainder and data bits
  always_comb begin
    r_in  = head_item.start ? CRC_ONES : rem_r;
    vec   = {head_item.data, r_in};
    r_new = '0;
    for (int k = 0; k < IN_BITS; k++) begin
      if (vec[k]) r_new = r_new ^ FOLD_MAT[head_item.cnt_m1][k];
    end
  end

  assign out_valid_nxt = pop | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) rem_r <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      crc_r   <= head_item.last ? (r_new ^ CRC_ONES) : r_new;
      final_r <= head_item.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = crc_r;
  assign out_tlast  = final_r;

endmodule

// ----- rtl/crc32_reflected_accumulator.sv -----
// channel  | dir | ports                          | contents
// ---------+-----+--------------------------------+----------------------------------
// in       | in  | in_tvalid/tready/tdata/tuser   | tdata: data_word[63:0]
//          |     | in_tlast                       | tuser: size_code[1:0], start_req[2]
//          |     |                                | tlast: last
// out      | out | out_tvalid/tready/tdata/tlast  | tdata: crc_value[31:0]
//          |     |                                | tlast: is_final
//
// one word per cycle sustained while out_tready stays high; the remainder loop is a single xor matrix
// per cycle (one column set per byte count), which sets that figure
// an input word is written into the queue, then folded into the output register
// synchronous active-low reset; remainder comes up all ones, queue empty
// a two-entry queue parts front and back; in_tready drops only when it is full
// a result held under out_tready low stalls the back while the front keeps filling
module crc32_reflected_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [crc32ra_pkg::DATA_W-1:0]      in_tdata,   // data_word
  input  logic [crc32ra_pkg::IN_USER_W-1:0]   in_tuser,   // size_code, start_req
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [crc32ra_pkg::CRC_W-1:0]       out_tdata,  // crc_value
  output logic                                out_tlast
);
  import crc32ra_pkg::*;

  // front to queue
  logic           push;
  crc32ra_item_t  push_item;
  // queue to back
  logic           pop;
  crc32ra_item_t  head_item;
  crc32ra_qstat_t q_stat;

  // classify the word: byte count, start and last flags
  crc32ra_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  crc32ra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // fold into the running remainder and hold the result word
  crc32ra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/crc32ra_checker.sv -----
module crc32ra_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [crc32ra_pkg::CRC_W-1:0]       out_tdata,
  input logic                                out_tlast
);
  import crc32ra_pkg::*;

  localparam int OUTS_W = $clog2(QDEPTH + 2);

  logic              in_acc;
  logic              out_acc;
  logic [OUTS_W-1:0] outs_r, outs_nxt;

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_tvalid & out_tready;
  assign outs_nxt = outs_r + OUTS_W'(in_acc) - OUTS_W'(out_acc);

  // words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) outs_r <= '0;
    else        outs_r <= outs_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> outs_r != '0)
    else $error("result word without an accepted input word");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outs_r <= OUTS_W'(QDEPTH + 1))
    else $error("more words in flight than queue and output register hold");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind crc32_reflected_accumulator crc32ra_checker u_crc32ra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
